// ===== src/lmdb_pkg.sv =====
// Shared types, constants and fixed-point helpers for the landmark back-projection block.
package lmdb_pkg;

  localparam int DATA_W = 32;
  localparam int WIDE_W = 64;
  localparam int HALF_W = 11;
  localparam int CFG_IDX_W = 3;
  localparam int SCALE_W = 33;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int DIV_STEPS = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;
  localparam logic signed [WIDE_W-1:0] ROUND_HALF = 64'sd32768;
  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] NARROW_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] NARROW_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CROP_M0      = 3'd0,
    REG_CROP_M1      = 3'd1,
    REG_CROP_M2      = 3'd2,
    REG_CROP_M3      = 3'd3,
    REG_CROP_M4      = 3'd4,
    REG_CROP_M5      = 3'd5,
    REG_HALF_SCALE   = 3'd6,
    REG_DEPTH_ENABLE = 3'd7
  } cfg_reg_e;

  typedef enum logic [4:0] {
    C_DET0, C_DET1, C_DET2,
    C_DIVSET, C_DIV, C_DIVEND,
    C_OFF0, C_OFF1, C_OFF2, C_OFF3, C_OFF4,
    C_SQ0, C_SQ1, C_SQ2, C_SQRT, C_SQEND,
    C_READY
  } coef_state_t;

  // Inverse transform and settings handed from the coefficient engine to the datapath.
  typedef struct packed {
    logic signed [DATA_W-1:0] i00;
    logic signed [DATA_W-1:0] i01;
    logic signed [DATA_W-1:0] i02;
    logic signed [DATA_W-1:0] i10;
    logic signed [DATA_W-1:0] i11;
    logic signed [DATA_W-1:0] i12;
    logic [SCALE_W-1:0]       scale;
    logic                     singular;
    logic [HALF_W-1:0]        half;
    logic                     depth_en;
    logic                     busy;
  } coef_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] d;
  } point_t;

  function automatic logic signed [WIDE_W-1:0] sat_add64(input logic signed [WIDE_W-1:0] a,
                                                         input logic signed [WIDE_W-1:0] b);
    logic signed [WIDE_W:0] s;
    s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
    if (s[WIDE_W] != s[WIDE_W-1]) begin
      return s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
    end
    return s[WIDE_W-1:0];
  endfunction

  function automatic logic signed [WIDE_W-1:0] sat_neg64(input logic signed [WIDE_W-1:0] a);
    return (a == WIDE_MIN) ? WIDE_MAX : -a;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > $signed({{(WIDE_W-DATA_W){1'b0}}, NARROW_MAX})) return NARROW_MAX;
    if (v < $signed({{(WIDE_W-DATA_W){1'b1}}, NARROW_MIN})) return NARROW_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Q32.32 to Q16.16, round half up, saturated.
  function automatic logic signed [DATA_W-1:0] round16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] t;
    t = sat_add64(v, ROUND_HALF);
    return sat32(t >>> 16);
  endfunction

endpackage

// ===== src/lmdb_ifs.sv =====
// Stream and configuration interfaces of the landmark back-projection block.
interface lmdb_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  raw_x;
  logic signed [31:0]  raw_y;
  logic signed [31:0]  raw_z;
  modport source (output valid, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface lmdb_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  img_x;
  logic signed [31:0]  img_y;
  logic signed [31:0]  img_z;
  logic                singular;
  modport source (output valid, img_x, img_y, img_z, singular, input ready);
  modport sink   (input valid, img_x, img_y, img_z, singular, output ready);
endinterface

interface lmdb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/lmdb_coef.sv =====
// Configuration registers and the multi-cycle engine that inverts the crop affine.
module lmdb_coef (
  input  logic          clk,
  input  logic          rst,
  lmdb_cfg_if.sink      cfg,
  output lmdb_pkg::coef_t coef
);
  import lmdb_pkg::*;

  logic signed [DATA_W-1:0] m [6];
  logic [HALF_W-1:0]        half;
  logic                     depth_en;

  coef_state_t state, state_next;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [WIDE_W-1:0] prod, acc, det;
  logic [WIDE_W-1:0]        dvd, quo, rem, divisor, sbit;
  logic                     neg;
  logic [1:0]               k;
  logic [5:0]               cnt;
  logic signed [DATA_W-1:0] inv [4];
  logic signed [DATA_W-1:0] i02, i12;
  logic [SCALE_W-1:0]       scale;
  logic                     singular;
  logic                     cfg_we;
  logic                     busy;

  logic signed [DATA_W:0]   num;
  logic [DATA_W:0]          num_abs;
  logic [WIDE_W-1:0]        det_abs;
  logic [WIDE_W:0]          rem_sh;
  logic [WIDE_W:0]          root_try;

  assign cfg.ready = 1'b1;
  assign cfg_we = cfg.valid;

  always_comb begin
    case (k)
      2'd0:    num = {m[4][DATA_W-1], m[4]};
      2'd1:    num = -{m[1][DATA_W-1], m[1]};
      2'd2:    num = -{m[3][DATA_W-1], m[3]};
      default: num = {m[0][DATA_W-1], m[0]};
    endcase
    num_abs = num[DATA_W] ? -num : num;
    det_abs = det[WIDE_W-1] ? -det : det;
    rem_sh = {rem, dvd[WIDE_W-1]};
    root_try = {1'b0, quo} + {1'b0, sbit};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      C_DET0:   state_next = C_DET1;
      C_DET1:   state_next = C_DET2;
      C_DET2:   state_next = C_DIVSET;
      C_DIVSET: state_next = (det == '0) ? C_READY : C_DIV;
      C_DIV:    state_next = (cnt == 6'(DIV_STEPS - 1)) ? C_DIVEND : C_DIV;
      C_DIVEND: state_next = (k == 2'd3) ? C_OFF0 : C_DIVSET;
      C_OFF0:   state_next = C_OFF1;
      C_OFF1:   state_next = C_OFF2;
      C_OFF2:   state_next = C_OFF3;
      C_OFF3:   state_next = C_OFF4;
      C_OFF4:   state_next = C_SQ0;
      C_SQ0:    state_next = C_SQ1;
      C_SQ1:    state_next = C_SQ2;
      C_SQ2:    state_next = C_SQRT;
      C_SQRT:   state_next = (cnt == 6'(SQRT_STEPS - 1)) ? C_SQEND : C_SQRT;
      C_SQEND:  state_next = C_READY;
      C_READY:  state_next = C_READY;
      default:  state_next = C_DET0;
    endcase
    if (cfg_we) state_next = C_DET0;
  end

  // Shared multiplier operands and status.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    busy = (state != C_READY);
    case (state)
      C_DET0:  begin mul_a = m[0];   mul_b = m[4];   end
      C_DET1:  begin mul_a = m[1];   mul_b = m[3];   end
      C_OFF0:  begin mul_a = inv[0]; mul_b = m[2];   end
      C_OFF1:  begin mul_a = inv[1]; mul_b = m[5];   end
      C_OFF2:  begin mul_a = inv[2]; mul_b = m[2];   end
      C_OFF3:  begin mul_a = inv[3]; mul_b = m[5];   end
      C_SQ0:   begin mul_a = inv[0]; mul_b = inv[0]; end
      C_SQ1:   begin mul_a = inv[1]; mul_b = inv[1]; end
      default: begin mul_a = '0;     mul_b = '0;     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_DET0;
      m[0] <= Q_ONE; m[1] <= '0; m[2] <= '0;
      m[3] <= '0; m[4] <= Q_ONE; m[5] <= '0;
      half <= HALF_W'(96);
      depth_en <= 1'b0;
      k <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_reg_e'(cfg.index))
          REG_CROP_M0:      m[0] <= cfg.data;
          REG_CROP_M1:      m[1] <= cfg.data;
          REG_CROP_M2:      m[2] <= cfg.data;
          REG_CROP_M3:      m[3] <= cfg.data;
          REG_CROP_M4:      m[4] <= cfg.data;
          REG_CROP_M5:      m[5] <= cfg.data;
          REG_HALF_SCALE:   half <= cfg.data[HALF_W-1:0];
          REG_DEPTH_ENABLE: depth_en <= cfg.data[0];
          default:          depth_en <= depth_en;
        endcase
      end
      case (state)
        C_DET2:   k <= '0;
        C_DIVSET: cnt <= '0;
        C_DIV:    cnt <= cnt + 6'd1;
        C_DIVEND: k <= k + 2'd1;
        C_SQ2:    cnt <= '0;
        C_SQRT:   cnt <= cnt + 6'd1;
        default:  cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      C_DET1: acc <= prod;
      C_DET2: det <= acc - prod;
      C_DIVSET: begin
        singular <= (det == '0);
        dvd <= {num_abs[DATA_W-1:0], {DATA_W{1'b0}}} + (det_abs >> 1);
        divisor <= det_abs;
        rem <= '0;
        quo <= '0;
        neg <= num[DATA_W] ^ det[WIDE_W-1];
      end
      C_DIV: begin
        dvd <= dvd << 1;
        if (rem_sh >= {1'b0, divisor}) begin
          rem <= WIDE_W'(rem_sh - {1'b0, divisor});
          quo <= {quo[WIDE_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[WIDE_W-1:0];
          quo <= {quo[WIDE_W-2:0], 1'b0};
        end
      end
      C_DIVEND: begin
        if (neg) begin
          inv[k] <= (quo > 64'h8000_0000) ? NARROW_MIN : -quo[DATA_W-1:0];
        end else begin
          inv[k] <= (quo > 64'h7FFF_FFFF) ? NARROW_MAX : quo[DATA_W-1:0];
        end
      end
      C_OFF1: acc <= prod;
      C_OFF2: i02 <= round16(sat_neg64(sat_add64(acc, prod)));
      C_OFF3: acc <= prod;
      C_OFF4: i12 <= round16(sat_neg64(sat_add64(acc, prod)));
      C_SQ1:  acc <= prod;
      C_SQ2: begin
        rem <= acc + prod;
        quo <= '0;
        sbit <= 64'd1 << 62;
      end
      C_SQRT: begin
        // One bit of the root per cycle.
        if ({1'b0, rem} >= root_try) begin
          rem <= WIDE_W'({1'b0, rem} - root_try);
          quo <= (quo >> 1) + sbit;
        end else begin
          quo <= quo >> 1;
        end
        sbit <= sbit >> 2;
      end
      C_SQEND: scale <= (rem > quo) ? quo[SCALE_W-1:0] + SCALE_W'(1) : quo[SCALE_W-1:0];
      default: acc <= acc;
    endcase
  end

  always_comb begin
    coef.i00 = inv[0];
    coef.i01 = inv[1];
    coef.i10 = inv[2];
    coef.i11 = inv[3];
    coef.i02 = i02;
    coef.i12 = i12;
    coef.scale = scale;
    coef.singular = singular;
    coef.half = half;
    coef.depth_en = depth_en;
    coef.busy = busy;
  end

endmodule

// ===== src/lmdb_front.sv =====
// Front end: accepts raw rows and scales them into crop coordinates.
module lmdb_front (
  lmdb_in_if.sink           pts,
  input  lmdb_pkg::coef_t   coef,
  input  logic              q_full,
  output logic              q_push,
  output lmdb_pkg::point_t  q_data
);
  import lmdb_pkg::*;

  logic signed [DATA_W:0]   xs, ys, zs;
  logic signed [HALF_W:0]   hs;
  logic signed [DATA_W+HALF_W+1:0] px, py, pz;

  assign pts.ready = !coef.busy && !q_full;
  assign q_push = pts.valid && pts.ready;

  always_comb begin
    hs = {1'b0, coef.half};
    xs = {pts.raw_x[DATA_W-1], pts.raw_x} + {1'b0, Q_ONE};
    ys = {pts.raw_y[DATA_W-1], pts.raw_y} + {1'b0, Q_ONE};
    zs = {pts.raw_z[DATA_W-1], pts.raw_z};
    px = xs * hs;
    py = ys * hs;
    pz = zs * hs;
    q_data.u = sat32(WIDE_W'(px));
    q_data.v = sat32(WIDE_W'(py));
    q_data.d = coef.depth_en ? sat32(WIDE_W'(pz)) : '0;
  end

endmodule

// ===== src/lmdb_queue.sv =====
// Short queue of scaled points between the front end and the datapath.
module lmdb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lmdb_pkg::point_t wdata,
  input  logic             pop,
  output lmdb_pkg::point_t rdata,
  output logic             full,
  output logic             empty
);
  import lmdb_pkg::*;

  point_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

endmodule

// ===== src/lmdb_back.sv =====
// Datapath: maps crop points through the inverse affine in a three-stage pipeline.
module lmdb_back (
  input  logic             clk,
  input  logic             rst,
  input  lmdb_pkg::coef_t  coef,
  input  lmdb_pkg::point_t q_data,
  input  logic             q_empty,
  output logic             q_pop,
  lmdb_out_if.source       res
);
  import lmdb_pkg::*;

  logic                     adv;
  logic                     s1_valid, s2_valid, s3_valid;
  logic signed [WIDE_W-1:0] p0, p1, p2, p3, pz;
  logic signed [WIDE_W-1:0] sa, sb;
  logic signed [DATA_W-1:0] z2;
  logic signed [DATA_W-1:0] x3, y3, z3;
  logic signed [WIDE_W+1:0] pz_full;
  logic signed [WIDE_W-1:0] off_x, off_y;

  // The whole pipe moves when the output slot is free or being taken.
  assign adv = !s3_valid || res.ready;
  assign q_pop = adv && !q_empty;

  assign pz_full = q_data.d * $signed({1'b0, coef.scale});
  assign off_x = {{(WIDE_W-DATA_W-16){coef.i02[DATA_W-1]}}, coef.i02, 16'b0};
  assign off_y = {{(WIDE_W-DATA_W-16){coef.i12[DATA_W-1]}}, coef.i12, 16'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= !q_empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= coef.i00 * q_data.u;
      p1 <= coef.i01 * q_data.v;
      p2 <= coef.i10 * q_data.u;
      p3 <= coef.i11 * q_data.v;
      pz <= pz_full[WIDE_W-1:0];
      sa <= sat_add64(p0, p1);
      sb <= sat_add64(p2, p3);
      z2 <= round16(pz);
      if (coef.singular) begin
        x3 <= '0;
        y3 <= '0;
        z3 <= '0;
      end else begin
        x3 <= round16(sat_add64(sa, off_x));
        y3 <= round16(sat_add64(sb, off_y));
        z3 <= z2;
      end
    end
  end

  assign res.valid = s3_valid;
  assign res.img_x = x3;
  assign res.img_y = y3;
  assign res.img_z = z3;
  assign res.singular = coef.singular;

endmodule

// ===== src/landmark_decode_backproject.sv =====
// Top level of the landmark decode and back-projection block.
// A landmark row can enter while earlier rows are still in flight: the front end
// scales it into crop coordinates on entry, a four-entry queue holds it, and a three-stage
// multiply, sum and round pipeline maps it through the inverted crop affine. After reset and
// after every configuration write the inverse is rebuilt by a single shared multiplier, a
// restoring divider (four quotients of 64 steps each) and a bit-serial square root of 32 steps,
// during which no row is accepted.
module landmark_decode_backproject (
  input  logic       clk,
  input  logic       rst,
  lmdb_in_if.sink    pts,
  lmdb_out_if.source res,
  lmdb_cfg_if.sink   cfg
);
  import lmdb_pkg::*;

  coef_t  coef;
  point_t q_wdata, q_rdata;
  logic   q_push, q_pop, q_full, q_empty;

  lmdb_coef u_coef (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .coef (coef)
  );

  lmdb_front u_front (
    .pts    (pts),
    .coef   (coef),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  lmdb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  lmdb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .coef    (coef),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

// ===== src/lmdb_checker.sv =====
// Port-level checks for the landmark back-projection block, bound to the top level.
module lmdb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] img_x,
  input logic [31:0] img_y,
  input logic [31:0] img_z,
  input logic        singular,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(img_x) && $stable(img_y) && $stable(img_z))
    else $error("result changed while stalled");

  // A singular transform yields zero coordinates.
  a_sing: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> img_x == 32'd0 && img_y == 32'd0 && img_z == 32'd0)
    else $error("singular result with nonzero coordinates");

  // A configuration write blocks new rows while the inverse is rebuilt.
  a_recalc: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("row accepted during coefficient rebuild");

  // Nothing comes out and no row is accepted in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind landmark_decode_backproject lmdb_checker u_lmdb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pts.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .img_x     (res.img_x),
  .img_y     (res.img_y),
  .img_z     (res.img_z),
  .singular  (res.singular),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready)
);

// ===== tb/sv/lmdb_tb_ifs.sv =====
// Testbench types: the record of one expected image point.
package lmdb_tb_types;
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sing;
  } image_point_t;
endpackage

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the landmark back-projection block with a fixed-point predictor.
module testbench;
  import lmdb_pkg::*;
  import lmdb_tb_types::*;

  localparam int LIMIT = 20000;

  logic clk;
  logic rst;
  lmdb_in_if  pts ();
  lmdb_out_if res ();
  lmdb_cfg_if cfg ();

  landmark_decode_backproject i_dut (.clk(clk), .rst(rst), .pts(pts), .res(res), .cfg(cfg));

  // Shadow copy of the configuration registers.
  logic signed [31:0] crop [6];
  logic [10:0]        half_q;
  logic               depth_q;

  image_point_t expected_points [$];
  int  errors;
  int  idle_cycles;
  bit  long_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp64(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return 64'sh7fffffffffffffff;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000000000000000;
    return s;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint to_q16(input longint v);
    return clamp32(clamp64(v, 32768) >>> 16);
  endfunction

  function automatic longint inverse_term(input longint num, input longint den);
    bit neg;
    logic [127:0] n, d, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = ((n << 32) + d / 2) / d;
    if (neg) return (q > 128'd2147483648) ? -64'sd2147483648 : -longint'(q);
    return (q > 128'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic longint unsigned root_rounded(input longint unsigned n);
    longint unsigned r, b, rem;
    r = 0;
    rem = n;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (rem > r) r += 1;
    return r;
  endfunction

  function automatic image_point_t backproject(input logic signed [31:0] rx,
                                               input logic signed [31:0] ry,
                                               input logic signed [31:0] rz);
    image_point_t p;
    longint m [6];
    longint h, u, v, d, det, a00, a01, a10, a11, a02, a12;
    longint unsigned sc;
    for (int k = 0; k < 6; k++) m[k] = crop[k];
    h = half_q;
    u = clamp32((longint'(rx) + 65536) * h);
    v = clamp32((longint'(ry) + 65536) * h);
    d = depth_q ? clamp32(longint'(rz) * h) : 0;
    det = m[0] * m[4] - m[1] * m[3];
    p.x = 0; p.y = 0; p.z = 0; p.sing = 1'b1;
    if (det == 0) return p;
    a00 = inverse_term(m[4], det);
    a01 = inverse_term(-m[1], det);
    a10 = inverse_term(-m[3], det);
    a11 = inverse_term(m[0], det);
    a02 = clamp64(a00 * m[2], a01 * m[5]);
    a02 = to_q16(a02 == 64'sh8000000000000000 ? 64'sh7fffffffffffffff : -a02);
    a12 = clamp64(a10 * m[2], a11 * m[5]);
    a12 = to_q16(a12 == 64'sh8000000000000000 ? 64'sh7fffffffffffffff : -a12);
    p.x = to_q16(clamp64(clamp64(a00 * u, a01 * v), a02 * 65536));
    p.y = to_q16(clamp64(clamp64(a10 * u, a11 * v), a12 * 65536));
    sc = root_rounded(longint'(a00 * a00) + longint'(a01 * a01));
    p.z = to_q16(d * longint'(sc));
    p.sing = 1'b0;
    return p;
  endfunction

  // Leaves valid high after the transaction; load_affine drops it at the end.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx <= REG_CROP_M5) crop[idx] = val;
    else if (idx == REG_HALF_SCALE) half_q = val[10:0];
    else depth_q = val[0];
    @(negedge clk);
  endtask

  task automatic wait_idle();
    pts.valid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Valid stays high after the transaction unless a gap follows; wait_idle drops it.
  task automatic send_row(input logic [31:0] rx, input logic [31:0] ry, input logic [31:0] rz,
                          input bit use_gaps);
    if (use_gaps && $urandom_range(0, 3) == 0) begin
      pts.valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(negedge clk);
    end
    pts.valid <= 1'b1;
    pts.raw_x <= rx;
    pts.raw_y <= ry;
    pts.raw_z <= rz;
    @(posedge clk);
    while (!pts.ready) @(posedge clk);
    expected_points.push_back(backproject(rx, ry, rz));
    @(negedge clk);
  endtask

  task automatic load_affine(input logic [31:0] a0, a1, a2, a3, a4, a5,
                             input logic [10:0] hs, input bit de);
    write_reg(REG_CROP_M0, a0);
    write_reg(REG_CROP_M1, a1);
    write_reg(REG_CROP_M2, a2);
    write_reg(REG_CROP_M3, a3);
    write_reg(REG_CROP_M4, a4);
    write_reg(REG_CROP_M5, a5);
    write_reg(REG_HALF_SCALE, {21'd0, hs});
    write_reg(REG_DEPTH_ENABLE, {31'd0, de});
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_field();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $urandom_range(0, 131072) - 65536;
    endcase
  endfunction

  // Receiver: random stalls plus one long hold-off so the internal queue fills.
  initial begin
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        res.ready <= 1'b0;
        repeat (60) @(negedge clk);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 5) == 0)
        res.ready <= 1'b0;
      else
        res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    image_point_t e;
    if (!rst && res.valid && res.ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: result with nothing expected: x=%0d y=%0d z=%0d s=%0b", $time,
                 res.img_x, res.img_y, res.img_z, res.singular);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (res.img_x !== e.x || res.img_y !== e.y || res.img_z !== e.z
            || res.singular !== e.sing) begin
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d s=%0b actual x=%0d y=%0d z=%0d s=%0b",
                   $time, e.x, e.y, e.z, e.sing, res.img_x, res.img_y, res.img_z,
                   res.singular);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles without any transaction; the coefficient rebuild is long.
  always @(posedge clk) begin
    if ((pts.valid && pts.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("landmark_decode_backproject verification failed");
      $finish;
    end
  end

  // Directed rows; expected values given where they are obvious at identity and half 96.
  typedef struct {
    logic [31:0] rx, ry, rz;
    bit          known;
    logic [31:0] ex, ey, ez;
  } row_t;

  row_t directed_rows [] = '{
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'd6291456, 32'd6291456, 32'd0},
    '{32'hffff0000, 32'hffff0000, 32'h00010000, 1'b1, 32'd0, 32'd0, 32'd0},
    '{32'h00010000, 32'h00010000, 32'h7fffffff, 1'b1, 32'd12582912, 32'd12582912, 32'd0},
    '{32'h7fffffff, 32'h80000000, 32'h80000000, 1'b1, 32'h7fffffff, 32'h80000000, 32'd0},
    '{32'h00008000, 32'hffff8000, 32'h00001234, 1'b0, 0, 0, 0}
  };

  initial begin
    image_point_t p;
    errors = 0;
    idle_cycles = 0;
    long_hold = 1'b0;
    rst = 1'b1;
    pts.valid = 1'b0; pts.raw_x = '0; pts.raw_y = '0; pts.raw_z = '0;
    cfg.valid = 1'b0; cfg.index = REG_CROP_M0; cfg.data = '0;
    crop = '{32'sd65536, 0, 0, 0, 32'sd65536, 0};
    half_q = 11'd96;
    depth_q = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[k]) begin
      send_row(directed_rows[k].rx, directed_rows[k].ry, directed_rows[k].rz, 1'b0);
      if (directed_rows[k].known) begin
        p = expected_points[$];
        if (p.x !== directed_rows[k].ex || p.y !== directed_rows[k].ey
            || p.z !== directed_rows[k].ez || p.sing !== 1'b0) begin
          $display("%0t: predictor disagrees with table row %0d", $time, k);
          errors++;
        end
        expected_points[$] = '{directed_rows[k].ex, directed_rows[k].ey,
                               directed_rows[k].ez, 1'b0};
      end
    end
    wait_idle();

    // Singular transform: all zero with the flag set.
    load_affine(32'h00010000, 32'h00020000, 0, 32'h00008000, 32'h00010000, 0, 11'd1, 1'b1);
    send_row(32'h00010000, 32'h00010000, 32'h00010000, 1'b0);
    expected_points[$] = '{0, 0, 0, 1'b1};
    wait_idle();

    // Extreme registers: largest terms, zero and top half scale, depth on.
    load_affine(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'h7fffffff,
                32'h80000000, 11'd2047, 1'b1);
    for (int k = 0; k < 6; k++) send_row(random_field(), random_field(), random_field(), 1'b0);
    wait_idle();
    load_affine(32'h00000001, 0, 32'h80000000, 0, 32'hffffffff, 32'h7fffffff, 11'd0, 1'b1);
    for (int k = 0; k < 6; k++) send_row(random_field(), random_field(), random_field(), 1'b0);
    wait_idle();

    // Random phases with a fresh affine each time; one phase fills the block.
    for (int ph = 0; ph < 16; ph++) begin
      load_affine($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 262144),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536) - 32768,
                  $urandom,
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536) - 32768,
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 262144),
                  $urandom, $urandom_range(0, 7) == 0 ? 11'($urandom) : 11'($urandom_range(1, 1024)),
                  $urandom_range(0, 1));
      if (ph == 3) long_hold = 1'b1;
      for (int k = 0; k < 50; k++)
        send_row(random_field(), random_field(), random_field(), k > 20 || ph != 3);
      wait_idle();
    end

    if (errors == 0) begin
      $display("landmark_decode_backproject verification clean");
    end else begin
      $display("landmark_decode_backproject verification failed");
    end
    $finish;
  end

endmodule
